// ----- src/cgvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgvs_pkg
// Shared types, register codes and arithmetic helpers of the color gradient
// vertex shader.
// ----------------------------------------------------------------------------
package cgvs_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_TIME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 3'd4;

	// axis mapping codes (unused codes map like x)
	localparam logic [2:0] AXIS_X      = 3'd0;
	localparam logic [2:0] AXIS_Y      = 3'd1;
	localparam logic [2:0] AXIS_Z      = 3'd2;
	localparam logic [2:0] AXIS_PLANAR = 3'd3;
	localparam logic [2:0] AXIS_SPHERE = 3'd4;
	localparam logic [2:0] AXIS_SINE   = 3'd5;

	// transaction kind on tuser
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_SHADE = 1'b1;

	// pipeline depths
	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES          = 32 / SQRT_STEPS_PER_STAGE;
	localparam int MAP_PRE_STAGES       = 2;  // squares, sum
	localparam int SINE_LAT             = 5;  // four polynomial stages, product
	localparam int SINE_PAD             = MAP_PRE_STAGES + SQRT_STAGES - SINE_LAT;

	// sine polynomial coefficients, Q16
	localparam logic [16:0] SIN_C1  = 17'd102944;
	localparam logic [15:0] SIN_C2  = 16'd42047;
	localparam logic [12:0] SIN_C3  = 13'd4639;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// one input transaction, unpacked
	typedef struct packed {
		logic        shade;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [3:0]  idx;
		logic [47:0] rgb;  // blue, green, red from the top bit down
	} vtx_t;

	// item traveling down the pipeline; val holds the mapped scalar
	typedef struct packed {
		logic        vld;
		logic        shade;
		logic [3:0]  idx;
		logic [47:0] rgb;
		logic [31:0] val;
	} item_t;

	// square root working state
	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	// one restoring step: consumes two radicand bits, yields one root bit
	function automatic sq_t sq_step(input sq_t s);
		sq_t         r;
		logic [35:0] cur;
		logic [35:0] trial;
		cur   = {s.rem, s.rad[63:62]};
		trial = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[61:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = 34'(cur - trial);
			r.root = {s.root[30:0], 1'b1};
		end else begin
			r.rem  = cur[33:0];
			r.root = {s.root[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ----- src/cgvs_sine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgvs_sine
// Four-stage polynomial sine of a Q0.16 phase in turns; magnitude and sign.
// ----------------------------------------------------------------------------
module cgvs_sine import cgvs_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] phase,
	output logic [16:0] mag,
	output logic        neg
);

	logic [16:0] u;
	logic [33:0] uu;
	logic [16:0] u_s1, u2_s1, u_s2, u2_s2, u_s3, poly2_s3, mag_s4;
	logic [15:0] poly1_s2;
	logic [1:0]  q_s1, q_s2, q_s3;
	logic        neg_s4;
	logic [29:0] m2;
	logic [32:0] m3;
	logic [33:0] m4;

	// quadrant fold, mirrored in odd quadrants
	always_comb begin
		if (phase[14])
			u = {15'(15'h4000 - {1'b0, phase[13:0]}), 2'b00};
		else
			u = {1'b0, phase[13:0], 2'b00};
		uu = 34'(u) * 34'(u);
		m2 = 30'(u2_s1) * 30'(SIN_C3);
		m3 = 33'(u2_s2) * 33'(poly1_s2);
		m4 = 34'(u_s3) * 34'(poly2_s3);
	end

	// stage 1: u and u^2
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u;
			u2_s1 <= uu[32:16];
			q_s1  <= phase[15:14];
		end
	end

	// stage 2: inner polynomial term
	always_ff @(posedge clk) begin
		if (en) begin
			poly1_s2 <= SIN_C2 - 16'(m2[29:16]);
			u_s2     <= u_s1;
			u2_s2    <= u2_s1;
			q_s2     <= q_s1;
		end
	end

	// stage 3: outer polynomial term
	always_ff @(posedge clk) begin
		if (en) begin
			poly2_s3 <= SIN_C1 - m3[32:16];
			u_s3     <= u_s2;
			q_s3     <= q_s2;
		end
	end

	// stage 4: final product, clamp to one
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4 <= (m4[33:16] > 18'(ONE_Q16)) ? ONE_Q16 : m4[32:16];
			neg_s4 <= q_s3[1];
		end
	end

	assign mag = mag_s4;
	assign neg = neg_s4;

endmodule

// ----- src/cgvs_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgvs_isqrt
// Pipelined floor square root of a 64-bit radicand, two root bits per stage.
// ----------------------------------------------------------------------------
module cgvs_isqrt import cgvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [63:0] radicand,
	input  item_t       in_item,
	output logic [31:0] root,
	output item_t       out_item
);

	sq_t   sq_s [SQRT_STAGES];
	item_t it_s [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		sq_t   src;
		sq_t   nxt;
		item_t tin;

		if (g == 0) begin : g_first
			assign src = '{rad: radicand, rem: '0, root: '0};
			assign tin = in_item;
		end else begin : g_next
			assign src = sq_s[g-1];
			assign tin = it_s[g-1];
		end

		always_comb begin
			nxt = src;
			for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++)
				nxt = sq_step(nxt);
		end

		// item control travels with the root bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				it_s[g] <= '0;
			end else if (en) begin
				it_s[g] <= tin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g] <= nxt;
			end
		end
	end

	assign root     = sq_s[SQRT_STAGES-1].root;
	assign out_item = it_s[SQRT_STAGES-1];

endmodule

// ----- src/cgvs_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgvs_map
// Maps a vertex to a scalar: an axis, a planar or spherical radius, or the
// product of two sines. Fixed latency, all paths aligned.
// ----------------------------------------------------------------------------
module cgvs_map import cgvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [2:0]  axis_mode,
	input  logic        in_vld,
	input  vtx_t        in_vtx,
	output item_t       out_item
);

	logic [31:0] ax, ay, az;
	logic [63:0] xx_s1, yy_s1, zz_s1, sum_s2;
	item_t       it_s1, it_s2, sq_item, out_s19, in_item;
	logic [31:0] root;
	logic [16:0] mag_a, mag_b;
	logic        neg_a, neg_b;
	logic [33:0] sprod;
	logic [31:0] sin_s5;
	logic [31:0] sin_pad_s [SINE_PAD];

	// magnitudes for the squares
	assign ax = in_vtx.x[31] ? 32'(-in_vtx.x) : in_vtx.x;
	assign ay = in_vtx.y[31] ? 32'(-in_vtx.y) : in_vtx.y;
	assign az = in_vtx.z[31] ? 32'(-in_vtx.z) : in_vtx.z;

	// direct axis value picked at entry
	always_comb begin
		in_item.vld   = in_vld;
		in_item.shade = in_vtx.shade;
		in_item.idx   = in_vtx.idx;
		in_item.rgb   = in_vtx.rgb;
		if (axis_mode == AXIS_Y)
			in_item.val = in_vtx.y;
		else if (axis_mode == AXIS_Z)
			in_item.val = in_vtx.z;
		else
			in_item.val = in_vtx.x;
	end

	// stage 1: squares; stage 2: sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1 <= '0;
			it_s2 <= '0;
		end else if (en) begin
			it_s1 <= in_item;
			it_s2 <= it_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= 64'(ax) * 64'(ay - ay + ax);
			yy_s1  <= 64'(ay) * 64'(ay);
			zz_s1  <= 64'(az) * 64'(az);
			sum_s2 <= xx_s1 + yy_s1 + ((axis_mode == AXIS_SPHERE) ? zz_s1 : 64'd0);
		end
	end

	cgvs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.radicand (sum_s2),
		.in_item  (it_s2),
		.root     (root),
		.out_item (sq_item)
	);

	// sine product path
	cgvs_sine u_sine_x (
		.clk   (clk),
		.en    (en),
		.phase (in_vtx.x[15:0]),
		.mag   (mag_a),
		.neg   (neg_a)
	);

	cgvs_sine u_sine_y (
		.clk   (clk),
		.en    (en),
		.phase (in_vtx.y[15:0]),
		.mag   (mag_b),
		.neg   (neg_b)
	);

	assign sprod = 34'(mag_a) * 34'(mag_b);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s5 <= (neg_a ^ neg_b) ? 32'(-32'(sprod[32:16])) : 32'(sprod[32:16]);
			sin_pad_s[0] <= sin_s5;
			for (int k = 1; k < SINE_PAD; k++)
				sin_pad_s[k] <= sin_pad_s[k-1];
		end
	end

	// final select of the mapped scalar
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s19 <= '0;
		end else if (en) begin
			out_s19 <= sq_item;
			if (axis_mode == AXIS_PLANAR || axis_mode == AXIS_SPHERE)
				out_s19.val <= root;
			else if (axis_mode == AXIS_SINE)
				out_s19.val <= sin_pad_s[SINE_PAD-1];
		end
	end

	assign out_item = out_s19;

endmodule

// ----- src/cgvs_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgvs_ramp
// Time offset and scale, reduction to a table position, color table with
// two read ports, and the linear blend of adjacent entries.
// ----------------------------------------------------------------------------
module cgvs_ramp import cgvs_pkg::*; #(
	parameter int MAX_COLORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [4:0]  color_count,
	input  logic [31:0] scale,
	input  logic        use_time,
	input  logic [31:0] time_offset,
	input  item_t       in_item,
	output logic        out_vld,
	output logic [47:0] out_rgb
);

	localparam int IDX_W = $clog2(MAX_COLORS);
	localparam int CNT_W = ($clog2(MAX_COLORS + 1) > 5) ? $clog2(MAX_COLORS + 1) : 5;

	logic [CNT_W-1:0]    cnt;
	logic [IDX_W-1:0]    span;
	logic [31:0]         prod;
	logic [IDX_W+15:0]   w;
	logic [IDX_W-1:0]    i2, widx;
	logic                wr_ok;
	item_t               it_s1, it_s2, it_s3, it_s4;
	logic [31:0]         ta_s1;
	logic [15:0]         frac_s2, f_s3, f_s4;
	logic [IDX_W-1:0]    i1_s3;
	logic [47:0]         rda_s4, rdb_s4, ca, cb, blend;
	logic                va_s4, vb_s4;
	logic [47:0]         mem [MAX_COLORS];
	logic [MAX_COLORS-1:0] ent_vld_q;
	logic                out_vld_s5;
	logic [47:0]         out_s5;

	// effective color count minus one
	always_comb begin
		cnt = CNT_W'(color_count);
		if (cnt < CNT_W'(2))
			span = IDX_W'(1);
		else if (cnt > CNT_W'(MAX_COLORS))
			span = IDX_W'(MAX_COLORS - 1);
		else
			span = IDX_W'(cnt - CNT_W'(1));
	end

	// only the low 32 product bits matter: the position is (s mod 1) * span
	assign prod  = ta_s1 * scale;
	assign w     = (IDX_W + 16)'(span) * (IDX_W + 16)'(frac_s2);
	assign i2    = i1_s3 + IDX_W'(1);
	assign widx  = IDX_W'(it_s3.idx);
	assign wr_ok = en && it_s3.vld && (it_s3.shade == MODE_LOAD)
	               && (32'(it_s3.idx) < 32'(MAX_COLORS));

	// item control down the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1      <= '0;
			it_s2      <= '0;
			it_s3      <= '0;
			it_s4      <= '0;
			out_vld_s5 <= 1'b0;
		end else if (en) begin
			it_s1      <= in_item;
			it_s2      <= it_s1;
			it_s3      <= it_s2;
			it_s4      <= it_s3;
			out_vld_s5 <= it_s4.vld && (it_s4.shade == MODE_SHADE);
		end
	end

	// time add, scale, table position
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1   <= in_item.val + (use_time ? time_offset : 32'd0);
			frac_s2 <= prod[31:16];
			i1_s3   <= w[IDX_W+15:16];
			f_s3    <= w[15:0];
			f_s4    <= f_s3;
		end
	end

	// entry valid bits: unwritten entries read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_ok) begin
			ent_vld_q[widx] <= 1'b1;
		end
	end

	// color table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_ok)
			mem[widx] <= it_s3.rgb;
		if (en) begin
			rda_s4 <= mem[i1_s3];
			rdb_s4 <= mem[i2];
			va_s4  <= ent_vld_q[i1_s3];
			vb_s4  <= ent_vld_q[i2];
		end
	end

	assign ca = va_s4 ? rda_s4 : 48'd0;
	assign cb = vb_s4 ? rdb_s4 : 48'd0;

	// per channel blend with rounding
	always_comb begin
		logic [16:0] inv;
		logic [32:0] v;
		inv = ONE_Q16 - 17'(f_s4);
		for (int c = 0; c < 3; c++) begin
			v = 33'(ca[16*c +: 16]) * 33'(inv) + 33'(cb[16*c +: 16]) * 33'(f_s4)
			    + 33'd32768;
			blend[16*c +: 16] = v[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5 <= blend;
		end
	end

	assign out_vld = out_vld_s5;
	assign out_rgb = out_s5;

endmodule

// ----- src/color_gradient_vertex_shader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_gradient_vertex_shader
// Colors vertices from a gradient table; loads table entries in-stream.
//
//   channel   dir  payload                                   handshake
//   s_*       in   tdata: x, y, z, entry index, r, g, b;     tvalid/tready
//                  tuser: mode (0 load, 1 shade)
//   m_*       out  tdata: red, green, blue                   tvalid/tready
//   cfg_*     in   register index, write data                cfg_we
//
// One transaction per cycle sustained while results are taken. Results
// pass the 16-stage square root pipeline (two root bits a stage).
// A load transaction gives no result; it writes the table in stream order.
// A held result stalls the whole pipeline in place; reset empties it and
// clears the table to black.
// ----------------------------------------------------------------------------
module color_gradient_vertex_shader import cgvs_pkg::*; #(
	parameter int MAX_COLORS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// vertex / load stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [151:0]          s_tdata,   // x_coord, y_coord, z_coord, entry_index,
	                                         // red_in, green_in, blue_in, zero pad
	input  logic                  s_tuser,   // mode
	// color stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // red_out, green_out, blue_out
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2:0]  axis_mode_q;
	logic [4:0]  color_count_q;
	logic [31:0] scale_q;
	logic        use_time_q;
	logic [31:0] time_offset_q;
	logic        en;
	vtx_t        vtx;
	item_t       map_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_mode_q   <= AXIS_Y;
			color_count_q <= 5'd2;
			scale_q       <= 32'h0001_0000;
			use_time_q    <= 1'b0;
			time_offset_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AXIS_MODE:   axis_mode_q   <= cfg_data[2:0];
				CFG_COLOR_COUNT: color_count_q <= cfg_data[4:0];
				CFG_SCALE:       scale_q       <= cfg_data;
				CFG_USE_TIME:    use_time_q    <= cfg_data[0];
				CFG_TIME_OFFSET: time_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a result is held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// unpack the input transaction
	assign vtx.shade = s_tuser;
	assign vtx.x     = s_tdata[31:0];
	assign vtx.y     = s_tdata[63:32];
	assign vtx.z     = s_tdata[95:64];
	assign vtx.idx   = s_tdata[99:96];
	assign vtx.rgb   = s_tdata[147:100];

	cgvs_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.axis_mode (axis_mode_q),
		.in_vld    (s_tvalid),
		.in_vtx    (vtx),
		.out_item  (map_item)
	);

	cgvs_ramp #(
		.MAX_COLORS (MAX_COLORS)
	) u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.color_count (color_count_q),
		.scale       (scale_q),
		.use_time    (use_time_q),
		.time_offset (time_offset_q),
		.in_item     (map_item),
		.out_vld     (m_tvalid),
		.out_rgb     (m_tdata)
	);

endmodule
